// ===== design/sqvs_pkg.sv =====
// Shared types, constants and helpers for the sprite quad vertex setup core.
package sqvs_pkg;

  localparam int unsigned CfgW     = 14;
  localparam int unsigned CordW    = 34;   // CORDIC x/y, Q2.30 plus headroom
  localparam int unsigned AngW     = 33;   // CORDIC residual angle
  localparam int unsigned ProdW    = 51;   // 34 x 17 signed products
  localparam int unsigned SumW     = 52;   // rotated corner, scaled by 2^30
  localparam int unsigned DivW     = 32;   // dividend and quotient bits
  localparam int unsigned MaxSteps = 24;

  localparam logic signed [CordW-1:0] GainQ30 = 34'sh026DD3B6A;

  localparam logic [31:0] AtanTab [MaxSteps] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  typedef enum logic [2:0] {
    CFG_VIEW_W = 3'd0,
    CFG_VIEW_H = 3'd1,
    CFG_TEX_W  = 3'd2,
    CFG_TEX_H  = 3'd3
  } cfg_idx_e;

  localparam logic [CfgW-1:0] ViewWRst = 14'd1280;
  localparam logic [CfgW-1:0] ViewHRst = 14'd720;
  localparam logic [CfgW-1:0] TexWRst  = 14'd16;
  localparam logic [CfgW-1:0] TexHRst  = 14'd16;

  // Side data that rides along the CORDIC chain.
  typedef struct packed {
    logic [1:0]         corner;
    logic               flip;
    logic signed [17:0] cx;
    logic signed [17:0] cy;
    logic signed [16:0] tx;
    logic signed [16:0] ty;
    logic [DivW-1:0]    unum;
    logic [DivW-1:0]    vnum;
  } cside_t;

  // Side data that rides along the divider chain.
  typedef struct packed {
    logic [1:0] corner;
    logic       negx;
    logic       negy;
  } dside_t;

  // A zero divisor acts as one.
  function automatic logic [CfgW-1:0] nz(input logic [CfgW-1:0] v);
    return (v == '0) ? CfgW'(1) : v;
  endfunction

endpackage

// ===== design/sqvs_cordic_cell.sv =====
// One CORDIC rotation step with its output register.
module sqvs_cordic_cell
  import sqvs_pkg::*;
#(
  parameter int STEP = 0
) (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic signed [CordW-1:0] x_i,
  input  logic signed [CordW-1:0] y_i,
  input  logic signed [AngW-1:0]  z_i,
  output logic signed [CordW-1:0] x_o,
  output logic signed [CordW-1:0] y_o,
  output logic signed [AngW-1:0]  z_o
);

  logic signed [CordW-1:0] xsh, ysh, x_d, y_d;
  logic signed [AngW-1:0]  at, z_d;

  always_comb begin
    xsh = x_i >>> STEP;
    ysh = y_i >>> STEP;
    at  = $signed({1'b0, AtanTab[STEP]});
    if (!z_i[AngW-1]) begin
      x_d = x_i - ysh;
      y_d = y_i + xsh;
      z_d = z_i - at;
    end else begin
      x_d = x_i + ysh;
      y_d = y_i - xsh;
      z_d = z_i + at;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_o <= x_d;
      y_o <= y_d;
      z_o <= z_d;
    end
  end

endmodule

// ===== design/sqvs_div_cell.sv =====
// One restoring-division step: one quotient bit per cell, registered.
module sqvs_div_cell
  import sqvs_pkg::*;
(
  input  logic            clk_i,
  input  logic            en_i,
  input  logic [CfgW-1:0] den_i,
  input  logic [DivW-1:0] num_i,
  input  logic [CfgW-1:0] rem_i,
  output logic [DivW-1:0] num_o,
  output logic [CfgW-1:0] rem_o
);

  logic [CfgW:0]   trial;
  logic            ge;
  logic [CfgW-1:0] rem_d;
  logic [DivW-1:0] num_d;

  always_comb begin
    trial = {rem_i, num_i[DivW-1]};
    ge    = trial >= {1'b0, den_i};
    rem_d = ge ? CfgW'(trial - {1'b0, den_i}) : trial[CfgW-1:0];
    // shift the quotient bit in as the dividend bit moves out
    num_d = {num_i[DivW-2:0], ge};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num_o <= num_d;
      rem_o <= rem_d;
    end
  end

endmodule

// ===== design/sprite_quad_vertex_setup_core.sv =====
// Top level of the rotated sprite quad to NDC vertex setup core.
// Each accepted sprite request produces four vertices (TL, TR, BL, BR), one per
// cycle while the output is not stalled. The corner issue stage sets the request
// rate: it sends one corner a cycle, unless stalled, down a chain of CORDIC cells
// (min(CORDIC_STEPS,24) of them) and then a chain of 32 divider cells, and the
// block takes the next request as the last corner of a request issues. A new
// request is taken while the previous one is still in the chains, and the whole
// pipeline holds while the output register is stalled.
module sprite_quad_vertex_setup_core
  import sqvs_pkg::*;
#(
  parameter int CORDIC_STEPS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [15:0] dest_x_i,
  input  logic signed [15:0] dest_y_i,
  input  logic signed [15:0] dest_w_i,
  input  logic signed [15:0] dest_h_i,
  input  logic        [15:0] turn_angle_i,
  input  logic        [15:0] src_x_i,
  input  logic        [15:0] src_y_i,
  input  logic        [15:0] src_w_i,
  input  logic        [15:0] src_h_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic        [1:0]  corner_o,
  output logic signed [15:0] ndc_x_o,
  output logic signed [15:0] ndc_y_o,
  output logic        [15:0] tex_u_o,
  output logic        [15:0] tex_v_o,
  output logic               last_corner_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic        [2:0]  cfg_index_i,
  input  logic [CfgW-1:0]    cfg_data_i
);

  localparam int NS = (CORDIC_STEPS > int'(MaxSteps)) ? int'(MaxSteps) : CORDIC_STEPS;

  // configuration
  logic [CfgW-1:0] vw_q, vh_q, tw_q, th_q;
  logic [CfgW-1:0] den_vw, den_vh, den_tw, den_th;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vw_q <= ViewWRst;
      vh_q <= ViewHRst;
      tw_q <= TexWRst;
      th_q <= TexHRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_VIEW_W: vw_q <= cfg_data_i;
        CFG_VIEW_H: vh_q <= cfg_data_i;
        CFG_TEX_W:  tw_q <= cfg_data_i;
        CFG_TEX_H:  th_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign den_vw = nz(vw_q);
  assign den_vh = nz(vh_q);
  assign den_tw = nz(tw_q);
  assign den_th = nz(th_q);

  // pipeline advance: everything moves unless the output holds a stalled vertex
  logic out_valid_q, adv;
  assign adv = !out_valid_q || !out_stall_i;

  // request hold and corner issue
  logic               hold_q;
  logic [1:0]         k_q;
  logic signed [15:0] dx_q, dy_q, dw_q, dh_q;
  logic [15:0]        ang_q, sx_q, sy_q, sw_q, sh_q;
  logic               acc;

  assign in_stall_o = hold_q && !(adv && (k_q == 2'd3));
  assign acc        = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q <= 1'b0;
      k_q    <= 2'd0;
    end else begin
      if (hold_q && adv) begin
        k_q <= k_q + 2'd1;
      end
      if (acc) begin
        hold_q <= 1'b1;
      end else if (hold_q && adv && (k_q == 2'd3)) begin
        hold_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      dx_q  <= dest_x_i;
      dy_q  <= dest_y_i;
      dw_q  <= dest_w_i;
      dh_q  <= dest_h_i;
      ang_q <= turn_angle_i;
      sx_q  <= src_x_i;
      sy_q  <= src_y_i;
      sw_q  <= src_w_i;
      sh_q  <= src_h_i;
    end
  end

  cside_t                 iss_d;
  logic signed [AngW-1:0] z_raw, z_fold;
  logic [16:0]            s_u, s_v;

  always_comb begin
    z_raw  = AngW'($signed({ang_q, 16'h0000}));
    z_fold = z_raw;
    iss_d.flip = 1'b0;
    // fold the angle into [-90, 90] degrees and negate the results later
    if (z_raw > 33'sh040000000) begin
      z_fold     = z_raw - 33'sh080000000;
      iss_d.flip = 1'b1;
    end else if (z_raw < -33'sh040000000) begin
      z_fold     = z_raw + 33'sh080000000;
      iss_d.flip = 1'b1;
    end
    iss_d.corner = k_q;
    iss_d.cx     = (18'(dx_q) <<< 1) + 18'(dw_q);
    iss_d.cy     = (18'(dy_q) <<< 1) + 18'(dh_q);
    iss_d.tx     = k_q[0] ? 17'(dw_q) : -17'(dw_q);
    iss_d.ty     = k_q[1] ? 17'(dh_q) : -17'(dh_q);
    s_u          = k_q[0] ? (17'(sx_q) + 17'(sw_q)) : 17'(sx_q);
    s_v          = k_q[1] ? (17'(sy_q) + 17'(sh_q)) : 17'(sy_q);
    iss_d.unum   = DivW'({s_u, 10'b0}) + DivW'(den_tw >> 1);
    iss_d.vnum   = DivW'({s_v, 10'b0}) + DivW'(den_th >> 1);
  end

  // CORDIC chain
  cside_t                  csd_q  [NS+1];
  logic                    cvld_q [NS+1];
  logic signed [AngW-1:0]  z0_q;
  logic signed [CordW-1:0] xw [NS+1];
  logic signed [CordW-1:0] yw [NS+1];
  logic signed [AngW-1:0]  zw [NS+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i <= NS; i++) cvld_q[i] <= 1'b0;
    end else if (adv) begin
      cvld_q[0] <= hold_q;
      for (int i = 1; i <= NS; i++) cvld_q[i] <= cvld_q[i-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      csd_q[0] <= iss_d;
      z0_q     <= z_fold;
      for (int i = 1; i <= NS; i++) csd_q[i] <= csd_q[i-1];
    end
  end

  assign xw[0] = GainQ30;
  assign yw[0] = '0;
  assign zw[0] = z0_q;

  for (genvar g = 0; g < NS; g++) begin : g_cordic
    sqvs_cordic_cell #(.STEP(g)) u_cell (
      .clk_i (clk_i),
      .en_i  (adv),
      .x_i   (xw[g]),
      .y_i   (yw[g]),
      .z_i   (zw[g]),
      .x_o   (xw[g+1]),
      .y_o   (yw[g+1]),
      .z_o   (zw[g+1])
    );
  end

  // multiply stage
  logic signed [CordW-1:0] cosv, sinv;
  logic signed [ProdW-1:0] ctx_q, sty_q, stx_q, cty_q;
  cside_t                  msd_q;
  logic                    mvld_q;

  assign cosv = csd_q[NS].flip ? -xw[NS] : xw[NS];
  assign sinv = csd_q[NS].flip ? -yw[NS] : yw[NS];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ctx_q <= cosv * csd_q[NS].tx;
      sty_q <= sinv * csd_q[NS].ty;
      stx_q <= sinv * csd_q[NS].tx;
      cty_q <= cosv * csd_q[NS].ty;
      msd_q <= csd_q[NS];
    end
  end

  // sum stage: add the rounding half divisor and drop the 2^20 scale
  logic signed [SumW-1:0] px, py;
  logic [DivW-1:0]        ax, ay;
  logic [DivW-1:0]        magx_q, magy_q, unum_q, vnum_q;
  dside_t                 asd_q;
  logic                   avld_q;

  always_comb begin
    px = (SumW'(msd_q.cx) <<< 30) + SumW'(ctx_q) - SumW'(sty_q)
         + SumW'({vw_q == '0 ? CfgW'(1) : vw_q, 19'b0});
    py = (SumW'(msd_q.cy) <<< 30) + SumW'(stx_q) + SumW'(cty_q)
         + SumW'({den_vh, 19'b0});
    ax = px[SumW-1:20];
    ay = py[SumW-1:20];
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      // floor division of a negative value: divide its complement, complement back
      magx_q       <= ax[DivW-1] ? ~ax : ax;
      magy_q       <= ay[DivW-1] ? ~ay : ay;
      asd_q.negx   <= ax[DivW-1];
      asd_q.negy   <= ay[DivW-1];
      asd_q.corner <= msd_q.corner;
      unum_q       <= msd_q.unum;
      vnum_q       <= msd_q.vnum;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mvld_q <= 1'b0;
      avld_q <= 1'b0;
    end else if (adv) begin
      mvld_q <= cvld_q[NS];
      avld_q <= mvld_q;
    end
  end

  // divider chain, four lanes
  logic [DivW-1:0] nxw [DivW+1];
  logic [DivW-1:0] nyw [DivW+1];
  logic [DivW-1:0] nuw [DivW+1];
  logic [DivW-1:0] nvw [DivW+1];
  logic [CfgW-1:0] rxw [DivW+1];
  logic [CfgW-1:0] ryw [DivW+1];
  logic [CfgW-1:0] ruw [DivW+1];
  logic [CfgW-1:0] rvw [DivW+1];
  dside_t          dsd_q  [DivW];
  logic            dvld_q [DivW];

  assign nxw[0] = magx_q;
  assign nyw[0] = magy_q;
  assign nuw[0] = unum_q;
  assign nvw[0] = vnum_q;
  assign rxw[0] = '0;
  assign ryw[0] = '0;
  assign ruw[0] = '0;
  assign rvw[0] = '0;

  for (genvar g = 0; g < DivW; g++) begin : g_div
    sqvs_div_cell u_dx (
      .clk_i (clk_i), .en_i (adv), .den_i (den_vw),
      .num_i (nxw[g]), .rem_i (rxw[g]), .num_o (nxw[g+1]), .rem_o (rxw[g+1])
    );
    sqvs_div_cell u_dy (
      .clk_i (clk_i), .en_i (adv), .den_i (den_vh),
      .num_i (nyw[g]), .rem_i (ryw[g]), .num_o (nyw[g+1]), .rem_o (ryw[g+1])
    );
    sqvs_div_cell u_du (
      .clk_i (clk_i), .en_i (adv), .den_i (den_tw),
      .num_i (nuw[g]), .rem_i (ruw[g]), .num_o (nuw[g+1]), .rem_o (ruw[g+1])
    );
    sqvs_div_cell u_dv (
      .clk_i (clk_i), .en_i (adv), .den_i (den_th),
      .num_i (nvw[g]), .rem_i (rvw[g]), .num_o (nvw[g+1]), .rem_o (rvw[g+1])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DivW; i++) dvld_q[i] <= 1'b0;
    end else if (adv) begin
      dvld_q[0] <= avld_q;
      for (int i = 1; i < DivW; i++) dvld_q[i] <= dvld_q[i-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dsd_q[0] <= asd_q;
      for (int i = 1; i < DivW; i++) dsd_q[i] <= dsd_q[i-1];
    end
  end

  // output stage: restore sign, offset and saturate
  logic signed [DivW+1:0] qx, qy, nxv, nyv;
  logic signed [15:0]     ndc_x_d, ndc_y_d;
  logic [15:0]            tex_u_d, tex_v_d;
  dside_t                 dlast;

  always_comb begin
    dlast = dsd_q[DivW-1];
    qx = dlast.negx ? ~$signed({2'b00, nxw[DivW]}) : $signed({2'b00, nxw[DivW]});
    qy = dlast.negy ? ~$signed({2'b00, nyw[DivW]}) : $signed({2'b00, nyw[DivW]});
    nxv = qx - 34'sd16384;
    nyv = 34'sd16384 - qy;
    if (nxv > 34'sd32767)       ndc_x_d = 16'sh7FFF;
    else if (nxv < -34'sd32768) ndc_x_d = 16'sh8000;
    else                        ndc_x_d = nxv[15:0];
    if (nyv > 34'sd32767)       ndc_y_d = 16'sh7FFF;
    else if (nyv < -34'sd32768) ndc_y_d = 16'sh8000;
    else                        ndc_y_d = nyv[15:0];
    tex_u_d = (nuw[DivW] > DivW'(16'hFFFF)) ? 16'hFFFF : nuw[DivW][15:0];
    tex_v_d = (nvw[DivW] > DivW'(16'hFFFF)) ? 16'hFFFF : nvw[DivW][15:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= dvld_q[DivW-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      corner_o      <= dlast.corner;
      last_corner_o <= (dlast.corner == 2'd3);
      ndc_x_o       <= ndc_x_d;
      ndc_y_o       <= ndc_y_d;
      tex_u_o       <= tex_u_d;
      tex_v_o       <= tex_v_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== tb/tb_sprite_quad_vertex_setup_core.sv =====
// Self-checking testbench for the sprite quad vertex setup core.
module tb_sprite_quad_vertex_setup_core;
  import sqvs_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Steps = 16;
  localparam int Drain = 120;
  localparam longint CycleLimit = 400000;

  typedef struct {
    logic [1:0]  corner;
    logic [15:0] ndc_x;
    logic [15:0] ndc_y;
    logic [15:0] tex_u;
    logic [15:0] tex_v;
    logic        last;
  } vertex_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic signed [15:0] dest_x_i = '0, dest_y_i = '0, dest_w_i = '0, dest_h_i = '0;
  logic [15:0] turn_angle_i = '0, src_x_i = '0, src_y_i = '0, src_w_i = '0;
  logic [15:0] src_h_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [1:0] corner_o;
  logic signed [15:0] ndc_x_o, ndc_y_o;
  logic [15:0] tex_u_o, tex_v_o;
  logic last_corner_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [2:0] cfg_index_i = '0;
  logic [CfgW-1:0] cfg_data_i = '0;

  sprite_quad_vertex_setup_core #(.CORDIC_STEPS(Steps)) i_dut (.*);

  vertex_t vertex_q[$];
  logic [CfgW-1:0] view_w = ViewWRst, view_h = ViewHRst;
  logic [CfgW-1:0] tex_w = TexWRst, tex_h = TexHRst;
  int errors = 0;
  int n_sent = 0;
  int n_seen = 0;
  bit idle_en = 1'b1;
  longint cycles = 0;

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("tb_sprite_quad_vertex_setup_core NOT OK");
      $finish;
    end
  end

  function automatic longint asr_s(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint floor_q(longint n, longint d);
    longint q;
    q = n / d;
    if ((n % d) != 0 && n < 0) q--;
    return q;
  endfunction

  function automatic longint clamp(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint eff(logic [CfgW-1:0] v);
    return v == '0 ? 1 : longint'(v);
  endfunction

  function automatic void rotor(logic [15:0] ang, output longint c, output longint s);
    longint z, x, y, nx;
    bit flip;
    z = longint'({ang, 16'h0000});
    x = 64'h26DD3B6A;
    y = 0;
    flip = 0;
    if (z >= 64'sh80000000) z -= 64'sh100000000;
    if (z > 64'sh40000000) begin
      z -= 64'sh80000000;
      flip = 1;
    end else if (z < -64'sh40000000) begin
      z += 64'sh80000000;
      flip = 1;
    end
    for (int i = 0; i < Steps && i < 24; i++) begin
      if (z >= 0) begin
        nx = x - asr_s(y, i);
        y = y + asr_s(x, i);
        z -= longint'(AtanTab[i]);
      end else begin
        nx = x + asr_s(y, i);
        y = y - asr_s(x, i);
        z += longint'(AtanTab[i]);
      end
      x = nx;
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function automatic logic [15:0] texel(longint s, longint t);
    return 16'(clamp((s * 1024 + t / 2) / t, 0, 65535));
  endfunction

  // Compute the four vertices of one quad and queue them.
  task automatic predict_quad(logic signed [15:0] dx, dy, dw, dh,
                              logic [15:0] ang, sx, sy, sw, sh);
    longint c, s, cx, cy, dvx, dvy, tx, ty, px, py;
    vertex_t v;
    rotor(ang, c, s);
    cx = (2 * longint'(dx) + longint'(dw)) <<< 30;
    cy = (2 * longint'(dy) + longint'(dh)) <<< 30;
    dvx = eff(view_w) << 20;
    dvy = eff(view_h) << 20;
    for (int k = 0; k < 4; k++) begin
      tx = k[0] ? longint'(dw) : -longint'(dw);
      ty = k[1] ? longint'(dh) : -longint'(dh);
      px = cx + c * tx - s * ty;
      py = cy + s * tx + c * ty;
      v.corner = 2'(k);
      v.ndc_x = 16'(clamp(floor_q(px + dvx / 2, dvx) - 16384, -32768, 32767));
      v.ndc_y = 16'(clamp(16384 - floor_q(py + dvy / 2, dvy), -32768, 32767));
      v.tex_u = texel(k[0] ? longint'(sx) + sw : longint'(sx), eff(tex_w));
      v.tex_v = texel(k[1] ? longint'(sy) + sh : longint'(sy), eff(tex_h));
      v.last = (k == 3);
      vertex_q.push_back(v);
    end
  endtask

  task automatic report(string what, longint got, longint want);
    errors++;
    if (errors <= 30) $display("mismatch %s: got %0h want %0h", what, got, want);
  endtask

  // Check each vertex transfer and randomly stall the output.
  initial begin
    vertex_t w;
    int hold;
    hold = 0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) begin
        n_seen++;
        if (vertex_q.size() == 0) report("unexpected vertex", corner_o, 0);
        else begin
          w = vertex_q.pop_front();
          if (corner_o !== w.corner) report("corner", corner_o, w.corner);
          if (ndc_x_o !== w.ndc_x) report("ndc_x", ndc_x_o, w.ndc_x);
          if (ndc_y_o !== w.ndc_y) report("ndc_y", ndc_y_o, w.ndc_y);
          if (tex_u_o !== w.tex_u) report("tex_u", tex_u_o, w.tex_u);
          if (tex_v_o !== w.tex_v) report("tex_v", tex_v_o, w.tex_v);
          if (last_corner_o !== w.last) report("last_corner", last_corner_o, w.last);
        end
      end
      if (hold > 0) hold--;
      else if (idle_en && $urandom_range(0, 7) == 0) hold = $urandom_range(1, 5);
      out_stall_i <= idle_en && hold > 0;
    end
  end

  // Valid stays high between back-to-back requests unless a random idle gap is inserted; wait_idle drops it.
  task automatic send_quad(logic signed [15:0] dx, dy, dw, dh,
                           logic [15:0] ang, sx, sy, sw, sh);
    if (idle_en && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    dest_x_i <= dx; dest_y_i <= dy; dest_w_i <= dw; dest_h_i <= dh;
    turn_angle_i <= ang;
    src_x_i <= sx; src_y_i <= sy; src_w_i <= sw; src_h_i <= sh;
    do @(posedge clk_i); while (in_stall_o);
    predict_quad(dx, dy, dw, dh, ang, sx, sy, sw, sh);
    n_sent++;
  endtask

  task automatic send_random(bit wide);
    logic signed [15:0] dx, dy, dw, dh;
    if (wide) begin
      dx = 16'($urandom); dy = 16'($urandom); dw = 16'($urandom); dh = 16'($urandom);
    end else begin
      dx = 16'($urandom_range(0, 20000) - 4000);
      dy = 16'($urandom_range(0, 12000) - 2000);
      dw = 16'($urandom_range(0, 4000) - 500);
      dh = 16'($urandom_range(0, 4000) - 500);
    end
    send_quad(dx, dy, dw, dh, 16'($urandom), 16'($urandom), 16'($urandom),
              16'($urandom), 16'($urandom));
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (vertex_q.size() != 0) @(posedge clk_i);
    repeat (Drain) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CfgW-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_VIEW_W: view_w = val;
      CFG_VIEW_H: view_h = val;
      CFG_TEX_W:  tex_w = val;
      CFG_TEX_H:  tex_h = val;
      default: ;
    endcase
  endtask

  task automatic write_all(logic [CfgW-1:0] vw, vh, tw, th);
    wait_idle();
    write_reg(CFG_VIEW_W, vw);
    write_reg(CFG_VIEW_H, vh);
    write_reg(CFG_TEX_W, tw);
    write_reg(CFG_TEX_H, th);
    cfg_valid_i <= 1'b0;
  endtask

  // Extremes of fields, quadrant boundaries and mirrored rectangles.
  task automatic test_directed();
    logic [15:0] angs[8] = '{16'h0000, 16'h4000, 16'h8000, 16'hC000,
                             16'h4001, 16'hBFFF, 16'hFFFF, 16'h2000};
    foreach (angs[i]) send_quad(3200, 1600, 640, 320, angs[i], 0, 0, 256, 256);
    send_quad(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'h1234,
              16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_quad(-16'sh8000, -16'sh8000, -16'sh8000, -16'sh8000, 16'h9000, 0, 0, 0, 0);
    send_quad(1000, 1000, -400, -200, 16'h0800, 16, 32, 48, 64);
    send_quad(0, 0, 0, 0, 16'h0000, 0, 0, 0, 0);
  endtask

  // Unusual register values: zero divisors, minimum and maximum sizes.
  task automatic test_config_extremes();
    write_all(0, 0, 0, 0);
    repeat (4) send_random(1'b0);
    send_quad(100, 100, 50, 50, 16'h0400, 1, 2, 3, 4);
    write_all(1, 1, 1, 1);
    repeat (4) send_random(1'b0);
    write_all(8192, 8192, 8192, 8192);
    repeat (4) send_random(1'b1);
    write_all(16383, 16383, 16383, 16383);
    repeat (3) send_random(1'b1);
  endtask

  // Random requests over several register settings; no idling at the end.
  task automatic test_random();
    write_all(ViewWRst, ViewHRst, TexWRst, TexHRst);
    repeat (40) send_random($urandom_range(0, 3) == 0);
    write_all(CfgW'($urandom_range(1, 8192)), CfgW'($urandom_range(1, 8192)),
              CfgW'($urandom_range(1, 8192)), CfgW'($urandom_range(1, 8192)));
    repeat (30) send_random($urandom_range(0, 3) == 0);
    wait_idle();
    idle_en = 1'b0;
    write_all(640, 480, 256, 128);
    repeat (20) send_random(1'b0);
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_config_extremes();
    test_random();
    wait_idle();
    $display("sent %0d sprite requests, checked %0d vertices", n_sent, n_seen);
    $display("register settings covered zero, one, 8192, 16383 and random values");
    if (errors == 0) $display("tb_sprite_quad_vertex_setup_core OK");
    else $display("tb_sprite_quad_vertex_setup_core NOT OK");
    $finish;
  end

endmodule

// ===== files.f =====
design/sqvs_pkg.sv
design/sqvs_cordic_cell.sv
design/sqvs_div_cell.sv
design/sprite_quad_vertex_setup_core.sv
tb/tb_sprite_quad_vertex_setup_core.sv
